>>> src/sldf_pkg.sv
// shared types and constants for the sync/length frame deframer
`timescale 1ns / 1ps
`default_nettype none

package sldf_pkg;

  localparam int ByteW = 8;
  localparam int LenW  = 16;

  localparam logic [ByteW-1:0] SYNC_FIRST  = 8'h94;
  localparam logic [ByteW-1:0] SYNC_SECOND = 8'hC3;

  // parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_SYNC2   = 5'b00010,
    PH_LEN_HI  = 5'b00100,
    PH_LEN_LO  = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  // registered input request handed to the parser
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } req_t;

endpackage

`default_nettype wire

>>> src/sldf_in_reg.sv
// input register stage: holds one received byte until the parser takes it
`timescale 1ns / 1ps
`default_nettype none

module sldf_in_reg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [sldf_pkg::ByteW-1:0] s_axis_tdata,  // [7:0] rx_byte
  input  wire logic                      take,
  output sldf_pkg::req_t                 req
);

  logic                      full;
  logic [sldf_pkg::ByteW-1:0] data;

  // free when empty or when the held byte leaves this cycle
  assign s_axis_tready = !full || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  // byte holding register
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      data <= s_axis_tdata;
    end
  end

  assign req.valid = full;
  assign req.data  = data;

endmodule

`default_nettype wire

>>> src/sldf_parser.sv
// sync hunt, length capture and payload count with the result register
`timescale 1ns / 1ps
`default_nettype none

module sldf_parser (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire sldf_pkg::req_t            req,
  output logic                           take,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [sldf_pkg::ByteW-1:0]     m_axis_tdata,  // [7:0] payload_byte
  output logic                           m_axis_tlast,  // frame_last
  output logic                           m_axis_tuser   // frame_empty
);

  sldf_pkg::phase_t           phase, phase_next;
  logic [sldf_pkg::LenW-1:0]  remaining, remaining_next;
  logic [sldf_pkg::ByteW-1:0] length_high, length_high_next;
  logic                       emit;
  logic                       emit_last;
  logic                       emit_empty;
  logic [sldf_pkg::ByteW-1:0] emit_data;
  logic [sldf_pkg::LenW-1:0]  len;

  // the held request moves on when the result slot is free
  assign take = req.valid && (!m_axis_tvalid || m_axis_tready);

  assign len = {length_high, req.data};

  // phase machine
  always_comb begin
    phase_next       = phase;
    remaining_next   = remaining;
    length_high_next = length_high;
    emit             = 1'b0;
    emit_last        = 1'b0;
    emit_empty       = 1'b0;
    emit_data        = req.data;
    unique case (phase)
      sldf_pkg::PH_SYNC2: begin
        if (req.data == sldf_pkg::SYNC_SECOND) begin
          phase_next = sldf_pkg::PH_LEN_HI;
        end else if (req.data != sldf_pkg::SYNC_FIRST) begin
          phase_next = sldf_pkg::PH_HUNT;
        end
      end
      sldf_pkg::PH_LEN_HI: begin
        length_high_next = req.data;
        phase_next       = sldf_pkg::PH_LEN_LO;
      end
      sldf_pkg::PH_LEN_LO: begin
        remaining_next = len;
        if (len == '0) begin
          phase_next = sldf_pkg::PH_HUNT;
          emit       = 1'b1;
          emit_last  = 1'b1;
          emit_empty = 1'b1;
          emit_data  = '0;
        end else begin
          phase_next = sldf_pkg::PH_PAYLOAD;
        end
      end
      sldf_pkg::PH_PAYLOAD: begin
        remaining_next = remaining - sldf_pkg::LenW'(1);
        emit           = 1'b1;
        if (remaining == sldf_pkg::LenW'(1)) begin
          phase_next = sldf_pkg::PH_HUNT;
          emit_last  = 1'b1;
        end
      end
      default: begin
        // hunting, and any stray code acts as hunting
        phase_next = (req.data == sldf_pkg::SYNC_FIRST) ? sldf_pkg::PH_SYNC2
                                                        : sldf_pkg::PH_HUNT;
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= sldf_pkg::PH_HUNT;
      remaining   <= '0;
      length_high <= '0;
    end else if (take) begin
      phase       <= phase_next;
      remaining   <= remaining_next;
      length_high <= length_high_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take && emit) begin
      m_axis_tdata <= emit_data;
      m_axis_tlast <= emit_last;
      m_axis_tuser <= emit_empty;
    end
  end

  // a payload phase always has bytes left to count
  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == sldf_pkg::PH_PAYLOAD) |-> (remaining != '0))
    else $error("payload phase with zero bytes remaining");

  // an empty-frame result is always the last one and carries a zero byte
  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
    else $error("empty frame result malformed");

  // zero length low byte yields an empty result next cycle
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    (take && phase == sldf_pkg::PH_LEN_LO && len == '0)
      |=> (m_axis_tvalid && m_axis_tuser))
    else $error("zero-length frame gave no empty result");

  // the last payload byte returns the parser to hunting
  a_last_hunt: assert property (@(posedge clk) disable iff (rst)
    (take && phase == sldf_pkg::PH_PAYLOAD && remaining == sldf_pkg::LenW'(1))
      |=> (phase == sldf_pkg::PH_HUNT && m_axis_tlast))
    else $error("frame end did not return to hunting");

endmodule

`default_nettype wire

>>> src/sync_length_frame_deframer.sv
// top level of the sync/length frame deframer
//
//   channel   dir  signals                     content
//   s_axis    in   tvalid tready tdata[7:0]    rx_byte
//   m_axis    out  tvalid tready tdata[7:0]    payload_byte
//                  tlast tuser                 frame_last, frame_empty
//
// one byte accepted per cycle, sustained while m_axis is ready
// the pipe is an input register and a result register; the 16-bit byte counter
// and phase machine sit between them
// a stalled m_axis holds both registers, so s_axis drops tready once both are full
// rst is synchronous, active high, and returns the parser to sync hunting
`timescale 1ns / 1ps
`default_nettype none

module sync_length_frame_deframer (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [sldf_pkg::ByteW-1:0] s_axis_tdata,  // [7:0] rx_byte
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [sldf_pkg::ByteW-1:0]      m_axis_tdata,  // [7:0] payload_byte
  output logic                            m_axis_tlast,  // frame_last
  output logic                            m_axis_tuser   // [0] frame_empty
);

  sldf_pkg::req_t req;
  logic           take;

  // input request register
  sldf_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .take          (take),
    .req           (req)
  );

  // frame parser and result register
  sldf_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .take          (take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// testbench for the sync/length frame deframer: byte stream stimulus, frame tracking, result check
`timescale 1ns / 1ps

module tb_top;

  localparam int StallLimit = 2000;
  localparam int DrainCycles = 8;

  // one expected output beat
  typedef struct packed {
    logic [sldf_pkg::ByteW-1:0] data;
    logic                       last;
    logic                       empty;
  } frame_beat_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [sldf_pkg::ByteW-1:0] s_axis_tdata = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [sldf_pkg::ByteW-1:0] m_axis_tdata;
  logic                       m_axis_tlast;
  logic                       m_axis_tuser;

  sync_length_frame_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // pending rx bytes and expected payload beats
  logic [sldf_pkg::ByteW-1:0] rx_bytes_q[$];
  frame_beat_t                frame_beats_q[$];

  // frame tracker state
  sldf_pkg::phase_t           parse_ph = sldf_pkg::PH_HUNT;
  logic [sldf_pkg::LenW-1:0]  bytes_left = '0;
  logic [sldf_pkg::ByteW-1:0] len_hi = '0;

  logic rx_taken = 1'b0;
  int   sent_n = 0;
  int   got_n = 0;
  int   frames_n = 0;
  int   empties_n = 0;
  int   err_n = 0;
  int   quiet_n = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // follow the byte stream and queue the beats it must produce
  task automatic track_frame(input logic [sldf_pkg::ByteW-1:0] b);
    logic [sldf_pkg::LenW-1:0] len;
    len = {len_hi, b};
    case (parse_ph)
      sldf_pkg::PH_SYNC2: begin
        if (b == sldf_pkg::SYNC_SECOND) parse_ph = sldf_pkg::PH_LEN_HI;
        else if (b != sldf_pkg::SYNC_FIRST) parse_ph = sldf_pkg::PH_HUNT;
      end
      sldf_pkg::PH_LEN_HI: begin
        len_hi = b;
        parse_ph = sldf_pkg::PH_LEN_LO;
      end
      sldf_pkg::PH_LEN_LO: begin
        if (len == '0) begin
          parse_ph = sldf_pkg::PH_HUNT;
          bytes_left = '0;
          frame_beats_q.push_back(frame_beat_t'{data: '0, last: 1'b1, empty: 1'b1});
        end else begin
          bytes_left = len;
          parse_ph = sldf_pkg::PH_PAYLOAD;
        end
      end
      sldf_pkg::PH_PAYLOAD: begin
        bytes_left = bytes_left - sldf_pkg::LenW'(1);
        frame_beats_q.push_back(frame_beat_t'{data: b, last: bytes_left == '0,
                                              empty: 1'b0});
        if (bytes_left == '0) parse_ph = sldf_pkg::PH_HUNT;
      end
      default: begin
        parse_ph = (b == sldf_pkg::SYNC_FIRST) ? sldf_pkg::PH_SYNC2 : sldf_pkg::PH_HUNT;
      end
    endcase
  endtask

  // payload byte, biased toward the sync values
  function automatic logic [sldf_pkg::ByteW-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return sldf_pkg::SYNC_FIRST;
      1: return sldf_pkg::SYNC_SECOND;
      default: return sldf_pkg::ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  // sync pair, big-endian length, payload
  task automatic add_frame(input logic [sldf_pkg::LenW-1:0] len);
    rx_bytes_q.push_back(sldf_pkg::SYNC_FIRST);
    rx_bytes_q.push_back(sldf_pkg::SYNC_SECOND);
    rx_bytes_q.push_back(len[15:8]);
    rx_bytes_q.push_back(len[7:0]);
    for (int i = 0; i < int'(len); i++) rx_bytes_q.push_back(pick_byte());
  endtask

  // driver: present the next rx byte at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || rx_taken) begin
      if (rx_bytes_q.size() != 0 &&
          ((sent_n >= 300 && sent_n < 550) || $urandom_range(0, 99) >= 35)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_bytes_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    m_axis_tready <= (got_n >= 200 && got_n < 450) || $urandom_range(0, 99) >= 35;
  end

  // accept rx bytes and update the tracker
  always @(posedge clk) begin
    if (rst) begin
      rx_taken   <= 1'b0;
      parse_ph   = sldf_pkg::PH_HUNT;
      bytes_left = '0;
      len_hi     = '0;
    end else begin
      rx_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        track_frame(s_axis_tdata);
        sent_n <= sent_n + 1;
      end
    end
  end

  // monitor: check each result beat against the oldest expectation
  always @(posedge clk) begin
    frame_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_n <= got_n + 1;
      if (frame_beats_q.size() == 0) begin
        $display("%0t: unexpected result data=%02h last=%0b empty=%0b",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        err_n <= err_n + 1;
      end else begin
        want = frame_beats_q.pop_front();
        if (want.last) frames_n <= frames_n + 1;
        if (want.empty) empties_n <= empties_n + 1;
        if (m_axis_tdata !== want.data) begin
          $display("%0t: payload_byte expected %02h actual %02h",
                   $time, want.data, m_axis_tdata);
          err_n <= err_n + 1;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: frame_last expected %0b actual %0b",
                   $time, want.last, m_axis_tlast);
          err_n <= err_n + 1;
        end
        if (m_axis_tuser !== want.empty) begin
          $display("%0t: frame_empty expected %0b actual %0b",
                   $time, want.empty, m_axis_tuser);
          err_n <= err_n + 1;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_n <= 0;
    end else if (quiet_n >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_n <= quiet_n + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int k;
    logic [sldf_pkg::ByteW-1:0] b;

    // noise while hunting, including both byte extremes
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(8'hFF);
    // broken sync pair
    rx_bytes_q.push_back(sldf_pkg::SYNC_FIRST);
    rx_bytes_q.push_back(8'h00);
    // repeated first sync byte, then an empty frame
    rx_bytes_q.push_back(sldf_pkg::SYNC_FIRST);
    add_frame(16'd0);
    // single byte frame
    add_frame(16'd1);
    rx_bytes_q[$] = 8'hFF;
    // sync bytes inside the payload are plain data
    add_frame(16'd3);
    rx_bytes_q[$-2] = sldf_pkg::SYNC_FIRST;
    rx_bytes_q[$-1] = sldf_pkg::SYNC_SECOND;
    rx_bytes_q[$]   = 8'h00;
    // lone second sync byte while hunting
    rx_bytes_q.push_back(sldf_pkg::SYNC_SECOND);

    // random part, mostly well-formed frames
    while (rx_bytes_q.size() < 580) begin
      k = $urandom_range(0, 99);
      if (k < 75) begin
        repeat ($urandom_range(0, 2))
          rx_bytes_q.push_back(sldf_pkg::ByteW'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0) rx_bytes_q.push_back(sldf_pkg::SYNC_FIRST);
        if ($urandom_range(0, 9) == 0) add_frame(16'd0);
        else add_frame(sldf_pkg::LenW'($urandom_range(1, 24)));
      end else if (k < 90) begin
        // first sync byte followed by anything but the second
        rx_bytes_q.push_back(sldf_pkg::SYNC_FIRST);
        do b = sldf_pkg::ByteW'($urandom_range(0, 255)); while (b == sldf_pkg::SYNC_SECOND);
        rx_bytes_q.push_back(b);
      end else begin
        rx_bytes_q.push_back(pick_byte());
      end
    end
    // long frames: one with the high length byte set, two with sync values as the low length byte, then a short one
    add_frame(16'h0100);
    add_frame(16'h00C3);
    add_frame(16'h0094);
    add_frame(16'd2);

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (rx_bytes_q.size() != 0 || s_axis_tvalid);
    do @(negedge clk); while (frame_beats_q.size() != 0);
    repeat (DrainCycles) @(negedge clk);

    $display("sent %0d rx bytes, checked %0d result beats", sent_n, got_n);
    $display("frames closed: %0d, of them empty: %0d", frames_n, empties_n);
    if (err_n == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
